// ===== hw/rtl/teq_pkg.sv =====
package teq_pkg;

    localparam logic [2:0] ACT_SCHEDULE  = 3'd0;
    localparam logic [2:0] ACT_STEP      = 3'd1;
    localparam logic [2:0] ACT_RUN_UNTIL = 3'd2;
    localparam logic [2:0] ACT_SET_PEND  = 3'd3;
    localparam logic [2:0] ACT_CLR_PEND  = 3'd4;
    localparam logic [2:0] ACT_RESTART   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [3:0] KIND_TIMER = 4'd0;

    localparam logic       REG_START_TIME = 1'b0;
    localparam logic       REG_TIMER_LINE = 1'b1;

    localparam logic [5:0] TIMER_LINE_RESET = 6'd28;

    localparam int IN_W = 112;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SERVE
    } teq_state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_res;
        logic serve;
    } teq_cmd_t;

    typedef struct packed {
        logic dispatch;
        logic pend_any;
        logic pend_last;
    } teq_sts_t;

endpackage

// ===== hw/rtl/teq_ctrl.sv =====
module teq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  teq_pkg::teq_sts_t sts,
    output teq_pkg::teq_cmd_t cmd
);
    import teq_pkg::*;

    teq_state_t state_reg;
    teq_state_t state_next;
    logic       ov_reg;
    logic       ov_next;
    logic       can_load;

    assign can_load = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_load)
                begin
                    state_next = sts.dispatch ? S_SERVE : S_IDLE;
                end
            end
            S_SERVE:
            begin
                if (can_load && (!sts.pend_any || sts.pend_last))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_EXEC:
            begin
                cmd.exec     = can_load;
                cmd.load_res = can_load && !sts.dispatch;
            end
            S_SERVE:
            begin
                cmd.serve = can_load;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.load_res || cmd.serve)
        begin
            ov_next = 1'b1;
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ===== hw/rtl/teq_datapath.sv =====
module teq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IRQ_LINES   = 64,
    parameter int CNT_W       = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  teq_pkg::teq_cmd_t  cmd,
    output teq_pkg::teq_sts_t  sts,
    input  logic [teq_pkg::IN_W-1:0] in_data,
    input  logic               cfg_wr,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic [1:0]         status,
    output logic               event_valid,
    output logic [3:0]         out_kind,
    output logic [31:0]        out_payload,
    output logic [31:0]        out_due,
    output logic               irq_valid,
    output logic [5:0]         irq_number,
    output logic               line_pending,
    output logic [31:0]        now_time,
    output logic [CNT_W-1:0]   queue_count,
    output logic               last
);
    import teq_pkg::*;

    logic [31:0] start_time_reg;
    logic [5:0]  timer_line_reg;

    logic [2:0]  act_reg;
    logic [31:0] delay_reg;
    logic [3:0]  kind_reg;
    logic [31:0] payload_reg;
    logic [31:0] deadline_reg;
    logic [5:0]  line_reg;

    logic [31:0] due_reg [QUEUE_DEPTH];
    logic [3:0]  qkind_reg [QUEUE_DEPTH];
    logic [31:0] qpay_reg [QUEUE_DEPTH];
    logic [31:0] due_next [QUEUE_DEPTH];
    logic [3:0]  qkind_next [QUEUE_DEPTH];
    logic [31:0] qpay_next [QUEUE_DEPTH];

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [31:0]          now_reg, now_next;
    logic [IRQ_LINES-1:0] pend_reg, pend_next;

    logic [3:0]  ev_kind_reg;
    logic [31:0] ev_pay_reg;
    logic [31:0] ev_due_reg;

    logic [1:0]  st_next;
    logic [31:0] new_due;
    logic [QUEUE_DEPTH-1:0] le;
    logic [IRQ_LINES-1:0] line_sel, timer_sel, low_mask;
    logic [5:0]  low_idx;
    logic        cnt_zero, full;

    assign new_due  = now_reg + delay_reg;
    assign cnt_zero = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        for (int i = 0; i < IRQ_LINES; i++)
        begin
            line_sel[i]  = (line_reg == 6'(i));
            timer_sel[i] = (timer_line_reg == 6'(i));
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            le[i] = (CNT_W'(i) < cnt_reg) && (due_reg[i] <= new_due);
        end
        low_mask = pend_reg & (~pend_reg + 1'b1);
        low_idx  = 6'd0;
        for (int i = IRQ_LINES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                low_idx = 6'(i);
            end
        end
    end

    assign sts.dispatch  = !cnt_zero && ((act_reg == ACT_STEP) ||
                           ((act_reg == ACT_RUN_UNTIL) && (due_reg[0] <= deadline_reg)));
    assign sts.pend_any  = |pend_reg;
    assign sts.pend_last = ((pend_reg & ~low_mask) == '0);

    always_comb
    begin
        due_next   = due_reg;
        qkind_next = qkind_reg;
        qpay_next  = qpay_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        pend_next  = pend_reg;
        st_next    = ST_OK;
        if (cmd.exec)
        begin
            if (sts.dispatch)
            begin
                // pop the head: every cell but the last takes its successor
                for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                begin
                    due_next[i]   = due_reg[i+1];
                    qkind_next[i] = qkind_reg[i+1];
                    qpay_next[i]  = qpay_reg[i+1];
                end
                cnt_next = cnt_reg - 1'b1;
                now_next = due_reg[0];
                if (qkind_reg[0] == KIND_TIMER)
                begin
                    pend_next = pend_reg | timer_sel;
                end
            end
            else
            begin
                case (act_reg)
                    ACT_SCHEDULE:
                    begin
                        if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                            begin
                                if (!le[i])
                                begin
                                    if (i == 0 || le[(i == 0) ? 0 : i-1])
                                    begin
                                        due_next[i]   = new_due;
                                        qkind_next[i] = kind_reg;
                                        qpay_next[i]  = payload_reg;
                                    end
                                    else
                                    begin
                                        due_next[i]   = due_reg[(i == 0) ? 0 : i-1];
                                        qkind_next[i] = qkind_reg[(i == 0) ? 0 : i-1];
                                        qpay_next[i]  = qpay_reg[(i == 0) ? 0 : i-1];
                                    end
                                end
                            end
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    ACT_STEP:
                    begin
                        st_next = ST_NONE;
                    end
                    ACT_RUN_UNTIL:
                    begin
                        now_next = deadline_reg;
                        st_next  = ST_NONE;
                    end
                    ACT_SET_PEND:
                    begin
                        pend_next = pend_reg | line_sel;
                    end
                    ACT_CLR_PEND:
                    begin
                        pend_next = pend_reg & ~line_sel;
                    end
                    ACT_RESTART:
                    begin
                        cnt_next  = '0;
                        pend_next = '0;
                        now_next  = start_time_reg;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
        end
        else if (cmd.serve)
        begin
            pend_next = pend_reg & ~low_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            timer_line_reg <= TIMER_LINE_RESET;
            cnt_reg        <= '0;
            now_reg        <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (cfg_index == REG_START_TIME)
                begin
                    start_time_reg <= cfg_data;
                end
                else
                begin
                    timer_line_reg <= cfg_data[5:0];
                end
            end
            cnt_reg  <= cnt_next;
            now_reg  <= now_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg   <= due_next;
        qkind_reg <= qkind_next;
        qpay_reg  <= qpay_next;
        if (cmd.load_in)
        begin
            act_reg      <= in_data[2:0];
            delay_reg    <= in_data[34:3];
            kind_reg     <= in_data[38:35];
            payload_reg  <= in_data[70:39];
            deadline_reg <= in_data[102:71];
            line_reg     <= in_data[108:103];
        end
        if (cmd.exec && sts.dispatch)
        begin
            ev_kind_reg <= qkind_reg[0];
            ev_pay_reg  <= qpay_reg[0];
            ev_due_reg  <= due_reg[0];
        end
        if (cmd.load_res)
        begin
            status       <= st_next;
            event_valid  <= 1'b0;
            out_kind     <= '0;
            out_payload  <= '0;
            out_due      <= '0;
            irq_valid    <= 1'b0;
            irq_number   <= '0;
            line_pending <= |(pend_next & line_sel);
            now_time     <= now_next;
            queue_count  <= cnt_next;
            last         <= 1'b1;
        end
        else if (cmd.serve)
        begin
            status       <= ST_OK;
            event_valid  <= 1'b1;
            out_kind     <= ev_kind_reg;
            out_payload  <= ev_pay_reg;
            out_due      <= ev_due_reg;
            irq_valid    <= sts.pend_any;
            irq_number   <= sts.pend_any ? low_idx : 6'd0;
            // every pending line is cleared by the end of a dispatch
            line_pending <= 1'b0;
            now_time     <= now_reg;
            queue_count  <= cnt_reg;
            last         <= !sts.pend_any || sts.pend_last;
        end
    end

endmodule

// ===== hw/rtl/timed_event_queue_with_irq_pending.sv =====
// Timed event queue with pending-interrupt servicing.
//
// Channels: s_* takes one command item (tdata packs action, delay, kind,
// payload, deadline and irq line); m_* returns result items, tlast marking the
// final result of a command. cfg_* writes start_time (index 0) or
// timer_irq_line (index 1); cfg_ready is always high.
// Sequence: a command is taken in the idle state and executed in the execute
// state; a non-dispatching command gives one result, registered at the end of
// its execute cycle. A dispatch pops the head in the execute cycle, then the
// serve stage emits one result per pending line (one if none is pending),
// lowest line first. The sorted insert is combinational across the register
// cell chain.
// Reset: queue empty, clock 0, pending bits clear, start_time 0, timer line 28.
// Stall: the output register holds its item while m_tready is low; the
// execute and serve stages wait until that register is free.
module timed_event_queue_with_irq_pending #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IRQ_LINES   = 64,
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int BODY_W = 111 + CNT_W,
    localparam int OUT_W  = ((BODY_W + 7) / 8) * 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // action[2:0], delay[34:3], event_kind[38:35], event_payload[70:39],
    // deadline[102:71], irq_line[108:103], zero fill
    input  logic [111:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // status[1:0], event_valid[2], out_kind[6:3], out_payload[38:7],
    // out_due[70:39], irq_valid[71], irq_number[77:72], line_pending[78],
    // now_time[110:79], queue_count from bit 111, zero fill
    output logic [OUT_W-1:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import teq_pkg::*;

    teq_cmd_t          cmd;
    teq_sts_t          sts;
    logic [1:0]        status;
    logic              event_valid;
    logic [3:0]        out_kind;
    logic [31:0]       out_payload;
    logic [31:0]       out_due;
    logic              irq_valid;
    logic [5:0]        irq_number;
    logic              line_pending;
    logic [31:0]       now_time;
    logic [CNT_W-1:0]  queue_count;

    assign cfg_ready = 1'b1;

    teq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    teq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IRQ_LINES   (IRQ_LINES),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_data      (s_tdata),
        .cfg_wr       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .event_valid  (event_valid),
        .out_kind     (out_kind),
        .out_payload  (out_payload),
        .out_due      (out_due),
        .irq_valid    (irq_valid),
        .irq_number   (irq_number),
        .line_pending (line_pending),
        .now_time     (now_time),
        .queue_count  (queue_count),
        .last         (m_tlast)
    );

    // pack the result fields, lowest field first
    assign m_tdata = OUT_W'({queue_count, now_time, line_pending, irq_number, irq_valid,
                             out_due, out_payload, out_kind, event_valid, status});

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (queue_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    // a serviced line is reported only with a dispatched event
    a_irq_with_event: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && irq_valid) |-> event_valid)
        else $error("irq result without event");

    // one command at a time: input closes after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

    // a non-dispatch result is always final
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !event_valid) |-> m_tlast)
        else $error("plain result not final");

endmodule
